// File: src/dmarf_pkg.sv
package dmarf_pkg;

   localparam int CHANNELS_DEFAULT = 7;
   localparam int SLOTS_PER_CHANNEL = 4;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_DONE  = 2'd2;

   localparam logic [1:0] SLOT_ADDRESS = 2'd0;
   localparam logic [1:0] SLOT_BLOCK   = 2'd1;
   localparam logic [1:0] SLOT_CONTROL = 2'd2;
   localparam logic [1:0] SLOT_SPARE   = 2'd3;

   localparam logic [2:0] HARDWIRED_CHANNEL = 3'd6;

   localparam logic [31:0] CTRL_MASK     = 32'h9177_0703;
   localparam logic [31:0] CTRL6_KEEP    = 32'h5100_0000;
   localparam logic [31:0] CTRL6_SET     = 32'h0000_0002;
   localparam logic [31:0] CTRL_START    = 32'h0100_0000;
   localparam logic [31:0] IRQ_CLR_MASK  = 32'h7FFF_803F;
   localparam logic [31:0] IRQ_LOAD_MASK = 32'h00FF_803F;
   localparam logic [31:0] IRQ_FLAGS     = 32'h7F00_0000;
   localparam logic [31:0] IRQ_MASTER    = 32'h8000_0000;
   localparam logic [31:0] IRQ_FORCE     = 32'h0000_8000;
   localparam logic [31:0] IRQ_ENABLE    = 32'h0080_0000;
   localparam logic [31:0] IRQ_FLAG0     = 32'h0100_0000;
   localparam logic [31:0] ADDR_MASK     = 32'h00FF_FFFF;

   localparam logic [6:0] OFS_PRIORITY    = 7'h70;
   localparam logic [6:0] OFS_IRQ         = 7'h74;
   localparam logic [6:0] OFS_COMMON_MASK = 7'h7C;

   // Master bit: force sets it, a clear enable drops it, an enabled flag sets it,
   // and otherwise it keeps its old value.
   function automatic logic [31:0] update_master(input logic [31:0] irq);
      logic [31:0] r;
      r = irq;
      if ((irq & IRQ_FORCE) != '0) begin
         r = irq | IRQ_MASTER;
      end else if ((irq & IRQ_ENABLE) == '0) begin
         r = irq & ~IRQ_MASTER;
      end else if ((irq[22:16] & irq[30:24]) != '0) begin
         r = irq | IRQ_MASTER;
      end
      return r;
   endfunction

endpackage

// File: src/dmarf_ifs.sv
interface dmarf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [6:0]  reg_offset;
   logic [31:0] write_data;
   logic [2:0]  done_channel;

   modport source (output valid, output cmd, output reg_offset, output write_data,
                    output done_channel, input ready);
   modport sink (input valid, input cmd, input reg_offset, input write_data,
                 input done_channel, output ready);
endinterface

interface dmarf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        irq_pulse;

   modport source (output valid, output read_data, output irq_pulse, input ready);
   modport sink (input valid, input read_data, input irq_pulse, output ready);
endinterface

// File: src/dmarf_ram.sv
module dmarf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 28
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: src/dma_register_file_with_irq.sv
// An accepted transfer registers its command and the read of the channel register RAM;
// the result then goes to the output register, and a result still waiting there holds
// the item, and the input, back. Items are taken one at a time: the input is closed from
// acceptance until the result and any write back to the channel register RAM are done.
// Reset is synchronous and active high: it clears the priority and interrupt
// registers and the per-entry valid bits of the RAM, so no clearing pass runs.
module dma_register_file_with_irq #(
   parameter int CHANNELS = dmarf_pkg::CHANNELS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   dmarf_req_if.sink    req_chan,
   dmarf_rsp_if.source  rsp_chan
);

   localparam int DEPTH = CHANNELS * dmarf_pkg::SLOTS_PER_CHANNEL;
   localparam int AW    = $clog2(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic              state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_read_data_ff;
   logic              rsp_irq_pulse_ff;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [31:0]       irq_ff, irq_in;
   logic [31:0]       priority_ff, priority_in;
   logic              rd_valid_ff;
   logic [1:0]        cmd_ff;
   logic [6:0]        ofs_ff;
   logic [31:0]       data_ff;
   logic [2:0]        dch_ff;

   logic              req_acc;
   logic              go;
   logic [4:0]        rd_sel;
   logic [AW-1:0]     rd_addr;
   logic [31:0]       ram_rd_data;
   logic [31:0]       ram_q;
   logic              wr_en;
   logic [4:0]        wr_sel;
   logic [AW-1:0]     wr_addr;
   logic [31:0]       wr_data;
   logic [31:0]       rd_result;
   logic              pulse;
   logic              in_chan;
   logic              dch_ok;
   logic [6:0]        common_ofs;
   logic [31:0]       irq_tmp;
   logic [31:0]       ctrl_tmp;

   assign req_acc        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign go             = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   // The RAM holds four slots per channel; a done event reads the control slot.
   assign rd_sel  = (req_chan.cmd == dmarf_pkg::CMD_DONE) ?
                    {req_chan.done_channel, dmarf_pkg::SLOT_CONTROL} :
                    req_chan.reg_offset[6:2];
   assign rd_addr = rd_sel[AW-1:0];

   dmarf_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_acc),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // An entry never written since reset reads as zero.
   assign ram_q      = rd_valid_ff ? ram_rd_data : '0;
   assign in_chan    = ({1'b0, ofs_ff[6:4]} < 4'(CHANNELS));
   assign dch_ok     = ({1'b0, dch_ff} < 4'(CHANNELS));
   assign common_ofs = ofs_ff & dmarf_pkg::OFS_COMMON_MASK;
   assign wr_sel     = (cmd_ff == dmarf_pkg::CMD_DONE) ?
                       {dch_ff, dmarf_pkg::SLOT_CONTROL} : ofs_ff[6:2];
   assign wr_addr    = wr_sel[AW-1:0];

   always_comb begin
      rd_result   = '0;
      pulse       = 1'b0;
      wr_en       = 1'b0;
      wr_data     = '0;
      irq_in      = irq_ff;
      priority_in = priority_ff;
      irq_tmp     = irq_ff;
      ctrl_tmp    = data_ff & dmarf_pkg::CTRL_MASK;
      if (ofs_ff[6:4] == dmarf_pkg::HARDWIRED_CHANNEL) begin
         ctrl_tmp = (ctrl_tmp & dmarf_pkg::CTRL6_KEEP) | dmarf_pkg::CTRL6_SET;
      end
      case (cmd_ff)
         dmarf_pkg::CMD_READ: begin
            if (in_chan) begin
               if (ofs_ff[3:2] != dmarf_pkg::SLOT_SPARE) begin
                  rd_result = ram_q;
               end
            end else if (common_ofs == dmarf_pkg::OFS_PRIORITY) begin
               rd_result = priority_ff;
            end else if (common_ofs == dmarf_pkg::OFS_IRQ) begin
               rd_result = irq_ff;
            end
         end
         dmarf_pkg::CMD_WRITE: begin
            if (in_chan) begin
               case (ofs_ff[3:2])
                  dmarf_pkg::SLOT_ADDRESS: begin
                     wr_en   = 1'b1;
                     wr_data = data_ff & dmarf_pkg::ADDR_MASK;
                  end
                  dmarf_pkg::SLOT_BLOCK: begin
                     wr_en   = 1'b1;
                     wr_data = data_ff;
                  end
                  dmarf_pkg::SLOT_CONTROL: begin
                     wr_en   = 1'b1;
                     wr_data = ctrl_tmp;
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
            end else if (common_ofs == dmarf_pkg::OFS_PRIORITY) begin
               priority_in = data_ff;
            end else if (common_ofs == dmarf_pkg::OFS_IRQ) begin
               irq_tmp = (irq_ff & ~dmarf_pkg::IRQ_CLR_MASK)
                         | (data_ff & dmarf_pkg::IRQ_LOAD_MASK);
               irq_tmp = irq_tmp & ~(data_ff & dmarf_pkg::IRQ_FLAGS);
               irq_in  = dmarf_pkg::update_master(irq_tmp);
               pulse   = irq_in[31] && !irq_ff[31];
            end
         end
         dmarf_pkg::CMD_DONE: begin
            if (dch_ok) begin
               wr_en   = 1'b1;
               wr_data = ram_q & ~dmarf_pkg::CTRL_START;
               irq_tmp = irq_ff | (dmarf_pkg::IRQ_FLAG0 << dch_ff);
               irq_in  = dmarf_pkg::update_master(irq_tmp);
               pulse   = irq_in[31] && !irq_ff[31];
            end
         end
         default: begin
            rd_result = '0;
         end
      endcase
      if (!go) begin
         wr_en       = 1'b0;
         irq_in      = irq_ff;
         priority_in = priority_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         irq_ff       <= '0;
         priority_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         irq_ff       <= irq_in;
         priority_ff  <= priority_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff      <= req_chan.cmd;
         ofs_ff      <= req_chan.reg_offset;
         data_ff     <= req_chan.write_data;
         dch_ff      <= req_chan.done_channel;
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (go) begin
         rsp_read_data_ff <= rd_result;
         rsp_irq_pulse_ff <= pulse;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_read_data_ff;
   assign rsp_chan.irq_pulse = rsp_irq_pulse_ff;

endmodule

// File: src/dmarf_checker.sv
module dmarf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data,
   input logic        rsp_irq_pulse
);

   logic [1:0] outstanding_ff;
   logic       last_pulse_ff;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         last_pulse_ff  <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_ff + 2'(req_acc) - 2'(rsp_acc);
         if (rsp_acc) begin
            last_pulse_ff <= rsp_irq_pulse;
         end
      end
   end

   // No result may be left over once reset has been applied.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Items are taken one at a time: an accepted transfer closes the input side.
   assert property (@(posedge clock) disable iff (reset) req_acc |=> !req_ready)
      else $error("input accepted again while an item is in progress");

   // Every result belongs to an accepted item, and at most two are in flight.
   assert property (@(posedge clock) disable iff (reset)
                    (outstanding_ff != 2'd3) && (!rsp_valid || outstanding_ff != 2'd0))
      else $error("result count does not match accepted items");

   // After a rise the master bit is set, so the next item cannot raise it again.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_acc && last_pulse_ff) |-> !rsp_irq_pulse)
      else $error("interrupt pulse on two results in a row");

   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=>
                    (rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_pulse)))
      else $error("stalled result changed");

endmodule

bind dma_register_file_with_irq dmarf_checker u_dmarf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data),
   .rsp_irq_pulse (rsp_chan.irq_pulse)
);
